[src/mips64_subset_execute_stage_core_macros.svh]
// Assertion macros for the MIPS64 subset execute stage.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef MIPS64_SUBSET_EXECUTE_STAGE_CORE_MACROS_SVH
`define MIPS64_SUBSET_EXECUTE_STAGE_CORE_MACROS_SVH

// Plain property, checked on every clock edge outside reset.
`define MEX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent from the next cycle on.
`define MEX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

[src/mips_ex_pkg.sv]
// Package for the MIPS64 subset execute stage: opcode, exception and memory codes.
// No dependencies; used by mips64_subset_execute_stage_core.
`timescale 1ns / 1ps

package mips_ex_pkg;

    typedef enum logic [4:0] {
        OP_ADDI  = 5'd0,
        OP_ADDIU = 5'd1,
        OP_J     = 5'd2,
        OP_JAL   = 5'd3,
        OP_LUI   = 5'd4,
        OP_ORI   = 5'd5,
        OP_SD    = 5'd6,
        OP_SW    = 5'd7,
        OP_LBU   = 5'd8,
        OP_LD    = 5'd9,
        OP_LHU   = 5'd10,
        OP_LW    = 5'd11,
        OP_ANDI  = 5'd12,
        OP_BEQ   = 5'd13,
        OP_BNE   = 5'd14,
        OP_ADD   = 5'd15,
        OP_ADDU  = 5'd16,
        OP_JR    = 5'd17,
        OP_JALR  = 5'd18,
        OP_SLL   = 5'd19,
        OP_SLT   = 5'd20,
        OP_NOP   = 5'd21
    } t_opcode;

    typedef enum logic [2:0] {
        EXC_NONE = 3'd0,
        EXC_OVF  = 3'd1,
        EXC_ADDR = 3'd2,
        EXC_RI   = 3'd3,
        EXC_NI   = 3'd4
    } t_exc;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_LOAD  = 2'd1,
        MEM_STORE = 2'd2
    } t_mem_op;

    typedef enum logic [1:0] {
        SIZE_BYTE   = 2'd0,
        SIZE_HALF   = 2'd1,
        SIZE_WORD   = 2'd2,
        SIZE_DOUBLE = 2'd3
    } t_mem_size;

    localparam logic [1:0] CFG_MODE_64BIT  = 2'd0;
    localparam logic [1:0] CFG_KERNEL_MODE = 2'd1;
    localparam logic [1:0] CFG_EXC_ENABLE  = 2'd2;

    localparam logic [4:0] LINK_REG = 5'd31;

endpackage

[src/mips64_subset_execute_stage_core.sv]
// A transaction accepted into the input register has its result strobed by o_done from the result register.
// Throughput: one transaction per cycle; the input register and the result register each
// hold one instruction, so o_busy stays low and the receiver cannot stall the stage.
// Reset (synchronous, active low) clears both valid flags and sets mode_64bit = 0,
// kernel_mode = 1 and exceptions_enabled = 1.
// Depends on mips_ex_pkg and mips64_subset_execute_stage_core_macros.svh.
`timescale 1ns / 1ps
`include "mips64_subset_execute_stage_core_macros.svh"

module mips64_subset_execute_stage_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Instruction transaction
    input  logic        i_start,
    output logic        o_busy,
    input  logic [4:0]  i_opcode,
    input  logic [63:0] i_rs_value,
    input  logic [63:0] i_rt_value,
    input  logic [15:0] i_immediate,
    input  logic [4:0]  i_rt_index,
    input  logic [4:0]  i_rd_index,
    input  logic [4:0]  i_shift_amount,
    input  logic [25:0] i_jump_target,
    input  logic [63:0] i_pc_value,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data,
    // Result
    output logic        o_done,
    output logic        o_reg_write,
    output logic [4:0]  o_reg_index,
    output logic [63:0] o_reg_data,
    output logic        o_pc_write,
    output logic [63:0] o_pc_target,
    output logic [1:0]  o_mem_op,
    output logic [1:0]  o_mem_size,
    output logic [31:0] o_mem_address,
    output logic [63:0] o_store_data,
    output logic [2:0]  o_exception
);

    // Configuration registers.
    logic r_mode_64bit;
    logic r_kernel_mode;
    logic r_exc_en;

    // Input register.
    logic        r_in_vld;
    logic [4:0]  r_op;
    logic [63:0] r_rs;
    logic [63:0] r_rt;
    logic [15:0] r_imm;
    logic [4:0]  r_rti;
    logic [4:0]  r_rdi;
    logic [4:0]  r_sa;
    logic [25:0] r_tgt;
    logic [63:0] r_pc;

    // Result register.
    logic        r_out_vld;
    logic        r_reg_write;
    logic [4:0]  r_reg_index;
    logic [63:0] r_reg_data;
    logic        r_pc_write;
    logic [63:0] r_pc_target;
    logic [1:0]  r_mem_op;
    logic [1:0]  r_mem_size;
    logic [31:0] r_mem_address;
    logic [63:0] r_store_data;
    logic [2:0]  r_exception;

    // Next result.
    logic        n_reg_write;
    logic [4:0]  n_reg_index;
    logic [63:0] n_reg_data;
    logic        n_pc_write;
    logic [63:0] n_pc_target;
    logic [1:0]  n_mem_op;
    logic [1:0]  n_mem_size;
    logic [31:0] n_mem_address;
    logic [63:0] n_store_data;
    logic [2:0]  n_exception;

    // Datapath terms.
    logic [31:0] imm_sx32;
    logic [31:0] addr_sum;
    logic [31:0] reg_sum;
    logic        addi_ovf;
    logic        add_ovf;
    logic [63:0] pc_m4;
    logic [63:0] jump_pc;
    logic [63:0] branch_pc;
    logic [31:0] sll_res;
    logic        slt_res;
    logic        chk;
    logic        ri;
    logic        accept;

    assign accept      = i_start && !o_busy;
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_64bit  <= 1'b0;
            r_kernel_mode <= 1'b1;
            r_exc_en      <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            priority case (i_cfg_index)
                mips_ex_pkg::CFG_MODE_64BIT:  r_mode_64bit  <= i_cfg_data;
                mips_ex_pkg::CFG_KERNEL_MODE: r_kernel_mode <= i_cfg_data;
                mips_ex_pkg::CFG_EXC_ENABLE:  r_exc_en      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_opcode;
            r_rs  <= i_rs_value;
            r_rt  <= i_rt_value;
            r_imm <= i_immediate;
            r_rti <= i_rt_index;
            r_rdi <= i_rd_index;
            r_sa  <= i_shift_amount;
            r_tgt <= i_jump_target;
            r_pc  <= i_pc_value;
        end
    end

    assign imm_sx32  = {{16{r_imm[15]}}, r_imm};
    assign addr_sum  = r_rs[31:0] + imm_sx32;
    assign reg_sum   = r_rt[31:0] + r_rs[31:0];
    assign addi_ovf  = ((r_rs[31] ^ addr_sum[31]) & (imm_sx32[31] ^ addr_sum[31]));
    assign add_ovf   = ((r_rt[31] ^ reg_sum[31]) & (r_rs[31] ^ reg_sum[31]));
    assign pc_m4     = r_pc - 64'd4;
    // J/JAL keep the top 36 bits of the delay-slot address.
    assign jump_pc   = {pc_m4[63:28], r_tgt, 2'b00};
    assign branch_pc = pc_m4 + {{46{r_imm[15]}}, r_imm, 2'b00};
    assign sll_res   = r_rt[31:0] << r_sa;
    assign slt_res   = $signed(r_rs) < $signed(r_rt);
    assign chk       = r_exc_en;
    assign ri        = !r_mode_64bit && !r_kernel_mode;

    always_comb begin
        n_reg_write   = 1'b0;
        n_reg_index   = 5'd0;
        n_reg_data    = 64'd0;
        n_pc_write    = 1'b0;
        n_pc_target   = 64'd0;
        n_mem_op      = mips_ex_pkg::MEM_NONE;
        n_mem_size    = mips_ex_pkg::SIZE_BYTE;
        n_mem_address = 32'd0;
        n_store_data  = 64'd0;
        n_exception   = mips_ex_pkg::EXC_NONE;

        unique case (mips_ex_pkg::t_opcode'(r_op))
            mips_ex_pkg::OP_ADDI, mips_ex_pkg::OP_ADDIU: begin
                if ((r_op == mips_ex_pkg::OP_ADDI) && chk && addi_ovf) begin
                    n_exception = mips_ex_pkg::EXC_OVF;
                end else begin
                    n_reg_write = 1'b1;
                    n_reg_index = r_rti;
                    n_reg_data  = {{32{addr_sum[31]}}, addr_sum};
                end
            end
            mips_ex_pkg::OP_J: begin
                n_pc_write  = 1'b1;
                n_pc_target = jump_pc;
            end
            mips_ex_pkg::OP_JAL: begin
                n_reg_write = 1'b1;
                n_reg_index = mips_ex_pkg::LINK_REG;
                n_reg_data  = r_pc;
                n_pc_write  = 1'b1;
                n_pc_target = jump_pc;
            end
            mips_ex_pkg::OP_LUI: begin
                n_reg_write = 1'b1;
                n_reg_index = r_rti;
                n_reg_data  = {{32{r_imm[15]}}, r_imm, 16'd0};
            end
            mips_ex_pkg::OP_ORI: begin
                n_reg_write = 1'b1;
                n_reg_index = r_rti;
                n_reg_data  = r_rs | {48'd0, r_imm};
            end
            mips_ex_pkg::OP_ANDI: begin
                n_reg_write = 1'b1;
                n_reg_index = r_rti;
                n_reg_data  = r_rs & {48'd0, r_imm};
            end
            mips_ex_pkg::OP_SD: begin
                // Reserved instruction takes priority over misalignment.
                if (chk && ri) begin
                    n_exception = mips_ex_pkg::EXC_RI;
                end else if (chk && (addr_sum[2:0] != 3'd0)) begin
                    n_exception = mips_ex_pkg::EXC_ADDR;
                end else begin
                    n_mem_op      = mips_ex_pkg::MEM_STORE;
                    n_mem_size    = mips_ex_pkg::SIZE_DOUBLE;
                    n_mem_address = addr_sum;
                    n_store_data  = r_rt;
                end
            end
            mips_ex_pkg::OP_SW: begin
                if (chk && (addr_sum[1:0] != 2'd0)) begin
                    n_exception = mips_ex_pkg::EXC_ADDR;
                end else begin
                    n_mem_op      = mips_ex_pkg::MEM_STORE;
                    n_mem_size    = mips_ex_pkg::SIZE_WORD;
                    n_mem_address = addr_sum;
                    n_store_data  = {32'd0, r_rt[31:0]};
                end
            end
            mips_ex_pkg::OP_LBU: begin
                n_reg_index   = r_rti;
                n_mem_op      = mips_ex_pkg::MEM_LOAD;
                n_mem_size    = mips_ex_pkg::SIZE_BYTE;
                n_mem_address = addr_sum;
            end
            mips_ex_pkg::OP_LD: begin
                if (chk && ri) begin
                    n_exception = mips_ex_pkg::EXC_RI;
                end else if (chk && (addr_sum[2:0] != 3'd0)) begin
                    n_exception = mips_ex_pkg::EXC_ADDR;
                end else begin
                    n_reg_index   = r_rti;
                    n_mem_op      = mips_ex_pkg::MEM_LOAD;
                    n_mem_size    = mips_ex_pkg::SIZE_DOUBLE;
                    n_mem_address = addr_sum;
                end
            end
            mips_ex_pkg::OP_LHU: begin
                if (chk && addr_sum[0]) begin
                    n_exception = mips_ex_pkg::EXC_ADDR;
                end else begin
                    n_reg_index   = r_rti;
                    n_mem_op      = mips_ex_pkg::MEM_LOAD;
                    n_mem_size    = mips_ex_pkg::SIZE_HALF;
                    n_mem_address = addr_sum;
                end
            end
            mips_ex_pkg::OP_LW: begin
                if (chk && (addr_sum[1:0] != 2'd0)) begin
                    n_exception = mips_ex_pkg::EXC_ADDR;
                end else begin
                    n_reg_index   = r_rti;
                    n_mem_op      = mips_ex_pkg::MEM_LOAD;
                    n_mem_size    = mips_ex_pkg::SIZE_WORD;
                    n_mem_address = addr_sum;
                end
            end
            mips_ex_pkg::OP_BEQ, mips_ex_pkg::OP_BNE: begin
                // A branch that is not taken leaves the whole result at zero.
                if ((r_rs == r_rt) == (r_op == mips_ex_pkg::OP_BEQ)) begin
                    n_pc_write  = 1'b1;
                    n_pc_target = branch_pc;
                end
            end
            mips_ex_pkg::OP_ADD, mips_ex_pkg::OP_ADDU: begin
                if ((r_op == mips_ex_pkg::OP_ADD) && chk && add_ovf) begin
                    n_exception = mips_ex_pkg::EXC_OVF;
                end else begin
                    n_reg_write = 1'b1;
                    n_reg_index = r_rdi;
                    n_reg_data  = {{32{reg_sum[31]}}, reg_sum};
                end
            end
            mips_ex_pkg::OP_JR, mips_ex_pkg::OP_JALR: begin
                if (chk && (r_rs[1:0] != 2'd0)) begin
                    n_exception = mips_ex_pkg::EXC_ADDR;
                end else begin
                    if (r_op == mips_ex_pkg::OP_JALR) begin
                        n_reg_write = 1'b1;
                        n_reg_index = r_rdi;
                        n_reg_data  = r_pc;
                    end
                    n_pc_write  = 1'b1;
                    n_pc_target = r_rs;
                end
            end
            mips_ex_pkg::OP_SLL: begin
                n_reg_write = 1'b1;
                n_reg_index = r_rdi;
                n_reg_data  = {{32{sll_res[31]}}, sll_res};
            end
            mips_ex_pkg::OP_SLT: begin
                n_reg_write = 1'b1;
                n_reg_index = r_rdi;
                n_reg_data  = {63'd0, slt_res};
            end
            mips_ex_pkg::OP_NOP: begin
            end
            default: begin
                n_exception = mips_ex_pkg::EXC_NI;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_reg_write   <= n_reg_write;
            r_reg_index   <= n_reg_index;
            r_reg_data    <= n_reg_data;
            r_pc_write    <= n_pc_write;
            r_pc_target   <= n_pc_target;
            r_mem_op      <= n_mem_op;
            r_mem_size    <= n_mem_size;
            r_mem_address <= n_mem_address;
            r_store_data  <= n_store_data;
            r_exception   <= n_exception;
        end
    end

    assign o_done        = r_out_vld;
    assign o_reg_write   = r_reg_write;
    assign o_reg_index   = r_reg_index;
    assign o_reg_data    = r_reg_data;
    assign o_pc_write    = r_pc_write;
    assign o_pc_target   = r_pc_target;
    assign o_mem_op      = r_mem_op;
    assign o_mem_size    = r_mem_size;
    assign o_mem_address = r_mem_address;
    assign o_store_data  = r_store_data;
    assign o_exception   = r_exception;

    `MEX_ASSERT_NEXT(a_result_follows, accept, ##1 o_done, "accepted transaction gave no result")
    `MEX_ASSERT(a_exc_no_writes, !(o_done && (o_exception != mips_ex_pkg::EXC_NONE)) || (!o_reg_write && !o_pc_write && (o_mem_op == mips_ex_pkg::MEM_NONE)), "exception result carries a write")
    `MEX_ASSERT(a_load_no_regwrite, !(o_done && (o_mem_op == mips_ex_pkg::MEM_LOAD)) || !o_reg_write, "load result requests a register write")
    `MEX_ASSERT(a_mem_no_pc, !(o_done && (o_mem_op != mips_ex_pkg::MEM_NONE)) || !o_pc_write, "memory request also redirects the PC")

endmodule

[dv/testbench.sv]
// Self-checking testbench for the MIPS64 subset execute stage.
// Depends on mips_ex_pkg and mips64_subset_execute_stage_core.
// A small scoreboard class predicts each result from the accepted instruction.
`timescale 1ns / 1ps

module testbench;
    import mips_ex_pkg::*;

    localparam logic [4:0] FIRST_UNIMPL_OP = 5'd22;
    localparam logic [4:0] LAST_UNIMPL_OP  = 5'd31;
    localparam int         MAX_PRINTED     = 40;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [63:0] rs_value;
        logic [63:0] rt_value;
        logic [15:0] immediate;
        logic [4:0]  rt_index;
        logic [4:0]  rd_index;
        logic [4:0]  shift_amount;
        logic [25:0] jump_target;
        logic [63:0] pc_value;
    } exec_instr_t;

    typedef struct packed {
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [63:0] reg_data;
        logic        pc_write;
        logic [63:0] pc_target;
        t_mem_op     mem_op;
        t_mem_size   mem_size;
        logic [31:0] mem_address;
        logic [63:0] store_data;
        t_exc        exc;
    } exec_result_t;

    class exec_result_tracker;
        exec_result_t pending_results[$];
        bit mode_64bit  = 1'b0;
        bit kernel_mode = 1'b1;
        bit exc_enabled = 1'b1;
        int errors;
        int instrs_noted;
        int results_checked;

        function void report_mismatch(string msg);
            if (errors < MAX_PRINTED) begin
                $display("MISMATCH at %0t ns: %s", $time, msg);
            end
            errors++;
        endfunction

        function void set_register(logic [1:0] idx, logic val);
            case (idx)
                CFG_MODE_64BIT:  mode_64bit = val;
                CFG_KERNEL_MODE: kernel_mode = val;
                CFG_EXC_ENABLE:  exc_enabled = val;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function exec_result_t predict_exec(exec_instr_t ins);
            exec_result_t r;
            logic [63:0]  simm;
            logic [31:0]  addr;
            logic [31:0]  sum;
            logic [31:0]  shifted;
            logic [63:0]  slot_pc;
            logic         chk;
            logic         ri;
            t_exc         exc;
            r       = '0;
            exc     = EXC_NONE;
            simm    = {{48{ins.immediate[15]}}, ins.immediate};
            addr    = ins.rs_value[31:0] + simm[31:0];
            slot_pc = ins.pc_value - 64'd4;
            chk     = exc_enabled;
            ri      = !mode_64bit && !kernel_mode;
            case (ins.opcode)
                OP_ADDI, OP_ADDIU: begin
                    sum = ins.rs_value[31:0] + simm[31:0];
                    if (ins.opcode == OP_ADDI && chk && ins.rs_value[31] == simm[31]
                            && sum[31] != ins.rs_value[31]) begin
                        exc = EXC_OVF;
                    end else begin
                        r.reg_write = 1'b1;
                        r.reg_index = ins.rt_index;
                        r.reg_data  = {{32{sum[31]}}, sum};
                    end
                end
                OP_J, OP_JAL: begin
                    if (ins.opcode == OP_JAL) begin
                        r.reg_write = 1'b1;
                        r.reg_index = LINK_REG;
                        r.reg_data  = ins.pc_value;
                    end
                    r.pc_write  = 1'b1;
                    r.pc_target = {slot_pc[63:28], ins.jump_target, 2'b00};
                end
                OP_LUI: begin
                    r.reg_write = 1'b1;
                    r.reg_index = ins.rt_index;
                    r.reg_data  = {{32{ins.immediate[15]}}, ins.immediate, 16'h0000};
                end
                OP_ORI, OP_ANDI: begin
                    r.reg_write = 1'b1;
                    r.reg_index = ins.rt_index;
                    r.reg_data  = (ins.opcode == OP_ORI) ? (ins.rs_value | {48'd0, ins.immediate})
                                                         : (ins.rs_value & {48'd0, ins.immediate});
                end
                OP_SD, OP_SW: begin
                    // Reserved instruction outranks misalignment for the doubleword store.
                    if (ins.opcode == OP_SD && chk && ri) begin
                        exc = EXC_RI;
                    end else if (chk && (ins.opcode == OP_SD ? addr[2:0] != 3'd0
                                                             : addr[1:0] != 2'd0)) begin
                        exc = EXC_ADDR;
                    end else begin
                        r.mem_op      = MEM_STORE;
                        r.mem_size    = (ins.opcode == OP_SD) ? SIZE_DOUBLE : SIZE_WORD;
                        r.mem_address = addr;
                        r.store_data  = (ins.opcode == OP_SD) ? ins.rt_value
                                                              : {32'd0, ins.rt_value[31:0]};
                    end
                end
                OP_LBU, OP_LD, OP_LHU, OP_LW: begin
                    if (ins.opcode == OP_LD && chk && ri) begin
                        exc = EXC_RI;
                    end else if (chk && ((ins.opcode == OP_LD && addr[2:0] != 3'd0)
                            || (ins.opcode == OP_LW && addr[1:0] != 2'd0)
                            || (ins.opcode == OP_LHU && addr[0]))) begin
                        exc = EXC_ADDR;
                    end else begin
                        r.reg_index   = ins.rt_index;
                        r.mem_op      = MEM_LOAD;
                        r.mem_address = addr;
                        case (ins.opcode)
                            OP_LBU:  r.mem_size = SIZE_BYTE;
                            OP_LHU:  r.mem_size = SIZE_HALF;
                            OP_LW:   r.mem_size = SIZE_WORD;
                            default: r.mem_size = SIZE_DOUBLE;
                        endcase
                    end
                end
                OP_BEQ, OP_BNE: begin
                    if ((ins.rs_value == ins.rt_value) == (ins.opcode == OP_BEQ)) begin
                        r.pc_write  = 1'b1;
                        r.pc_target = slot_pc + (simm << 2);
                    end
                end
                OP_ADD, OP_ADDU: begin
                    sum = ins.rt_value[31:0] + ins.rs_value[31:0];
                    if (ins.opcode == OP_ADD && chk && ins.rt_value[31] == ins.rs_value[31]
                            && sum[31] != ins.rt_value[31]) begin
                        exc = EXC_OVF;
                    end else begin
                        r.reg_write = 1'b1;
                        r.reg_index = ins.rd_index;
                        r.reg_data  = {{32{sum[31]}}, sum};
                    end
                end
                OP_JR, OP_JALR: begin
                    if (chk && ins.rs_value[1:0] != 2'd0) begin
                        exc = EXC_ADDR;
                    end else begin
                        if (ins.opcode == OP_JALR) begin
                            r.reg_write = 1'b1;
                            r.reg_index = ins.rd_index;
                            r.reg_data  = ins.pc_value;
                        end
                        r.pc_write  = 1'b1;
                        r.pc_target = ins.rs_value;
                    end
                end
                OP_SLL: begin
                    shifted     = ins.rt_value[31:0] << ins.shift_amount;
                    r.reg_write = 1'b1;
                    r.reg_index = ins.rd_index;
                    r.reg_data  = {{32{shifted[31]}}, shifted};
                end
                OP_SLT: begin
                    r.reg_write = 1'b1;
                    r.reg_index = ins.rd_index;
                    r.reg_data  = ($signed(ins.rs_value) < $signed(ins.rt_value)) ? 64'd1 : 64'd0;
                end
                OP_NOP: ;
                default: exc = EXC_NI;
            endcase
            if (exc != EXC_NONE) begin
                r     = '0;
                r.exc = exc;
            end
            return r;
        endfunction

        function void note_instruction(exec_instr_t ins);
            pending_results.push_back(predict_exec(ins));
            instrs_noted++;
        endfunction

        function void compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s is %h, expected %h (result %0d)",
                                          name, got, want, results_checked));
            end
        endfunction

        function void check_result(exec_result_t got);
            exec_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("result strobed with no instruction outstanding");
                return;
            end
            want = pending_results.pop_front();
            compare_field("reg_write", got.reg_write, want.reg_write);
            compare_field("reg_index", got.reg_index, want.reg_index);
            compare_field("reg_data", got.reg_data, want.reg_data);
            compare_field("pc_write", got.pc_write, want.pc_write);
            compare_field("pc_target", got.pc_target, want.pc_target);
            compare_field("mem_op", got.mem_op, want.mem_op);
            compare_field("mem_size", got.mem_size, want.mem_size);
            compare_field("mem_address", got.mem_address, want.mem_address);
            compare_field("store_data", got.store_data, want.store_data);
            compare_field("exception", got.exc, want.exc);
            results_checked++;
        endfunction

        function void report_leftovers();
            if (pending_results.size() != 0) begin
                report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [4:0]  i_opcode;
    logic [63:0] i_rs_value;
    logic [63:0] i_rt_value;
    logic [15:0] i_immediate;
    logic [4:0]  i_rt_index;
    logic [4:0]  i_rd_index;
    logic [4:0]  i_shift_amount;
    logic [25:0] i_jump_target;
    logic [63:0] i_pc_value;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic        i_cfg_data;
    logic        o_done;
    logic        o_reg_write;
    logic [4:0]  o_reg_index;
    logic [63:0] o_reg_data;
    logic        o_pc_write;
    logic [63:0] o_pc_target;
    logic [1:0]  o_mem_op;
    logic [1:0]  o_mem_size;
    logic [31:0] o_mem_address;
    logic [63:0] o_store_data;
    logic [2:0]  o_exception;

    exec_result_tracker tracker = new();
    exec_result_t       seen_result;
    exec_instr_t        seen_instr;

    mips64_subset_execute_stage_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_opcode       (i_opcode),
        .i_rs_value     (i_rs_value),
        .i_rt_value     (i_rt_value),
        .i_immediate    (i_immediate),
        .i_rt_index     (i_rt_index),
        .i_rd_index     (i_rd_index),
        .i_shift_amount (i_shift_amount),
        .i_jump_target  (i_jump_target),
        .i_pc_value     (i_pc_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_reg_write    (o_reg_write),
        .o_reg_index    (o_reg_index),
        .o_reg_data     (o_reg_data),
        .o_pc_write     (o_pc_write),
        .o_pc_target    (o_pc_target),
        .o_mem_op       (o_mem_op),
        .o_mem_size     (o_mem_size),
        .o_mem_address  (o_mem_address),
        .o_store_data   (o_store_data),
        .o_exception    (o_exception)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Everything is sampled at the edge, before any nonblocking update lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                seen_result.reg_write   = o_reg_write;
                seen_result.reg_index   = o_reg_index;
                seen_result.reg_data    = o_reg_data;
                seen_result.pc_write    = o_pc_write;
                seen_result.pc_target   = o_pc_target;
                seen_result.mem_op      = t_mem_op'(o_mem_op);
                seen_result.mem_size    = t_mem_size'(o_mem_size);
                seen_result.mem_address = o_mem_address;
                seen_result.store_data  = o_store_data;
                seen_result.exc         = t_exc'(o_exception);
                tracker.check_result(seen_result);
            end
            if (i_start && !o_busy) begin
                seen_instr = {i_opcode, i_rs_value, i_rt_value, i_immediate, i_rt_index,
                              i_rd_index, i_shift_amount, i_jump_target, i_pc_value};
                tracker.note_instruction(seen_instr);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.set_register(i_cfg_index, i_cfg_data);
            end
        end
    end

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(7))
            0: return 64'($urandom_range(255));
            1: begin
                case ($urandom_range(6))
                    0: return 64'd0;
                    1: return '1;
                    2: return 64'h0000_0000_7fff_ffff;
                    3: return 64'h0000_0000_8000_0000;
                    4: return 64'h8000_0000_0000_0000;
                    5: return 64'h7fff_ffff_ffff_ffff;
                    default: return 64'h0000_0000_ffff_ffff;
                endcase
            end
            2: begin
                logic [31:0] w;
                w = $urandom;
                return {{32{w[31]}}, w};
            end
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic exec_instr_t random_instr();
        exec_instr_t ins;
        ins.opcode = ($urandom_range(99) < 7) ? 5'($urandom_range(LAST_UNIMPL_OP, FIRST_UNIMPL_OP))
                                              : 5'($urandom_range(OP_NOP, OP_ADDI));
        ins.rs_value = pick_operand();
        ins.rt_value = ($urandom_range(9) < 2) ? ins.rs_value : pick_operand();
        case ($urandom_range(5))
            0: ins.immediate = 16'h0000;
            1: ins.immediate = 16'hffff;
            2: ins.immediate = ($urandom_range(1)) ? 16'h7fff : 16'h8000;
            default: ins.immediate = 16'($urandom);
        endcase
        ins.rt_index     = 5'($urandom);
        ins.rd_index     = 5'($urandom);
        ins.shift_amount = 5'($urandom);
        ins.jump_target  = 26'($urandom);
        ins.pc_value     = ($urandom_range(9) == 0) ? pick_operand() : {$urandom, $urandom};
        // Most memory accesses and register jumps are aligned so that they get past the checks.
        if ($urandom_range(9) < 7) begin
            case (ins.opcode)
                OP_SD, OP_SW, OP_LBU, OP_LD, OP_LHU, OP_LW:
                    ins.rs_value[2:0] = 3'(3'd0 - ins.immediate[2:0]);
                OP_JR, OP_JALR:
                    ins.rs_value[1:0] = 2'd0;
                default: ;
            endcase
        end
        return ins;
    endfunction

    function automatic exec_instr_t instr_with(logic [4:0] op, logic [63:0] rs, logic [63:0] rt,
                                               logic [15:0] imm);
        exec_instr_t ins;
        ins           = random_instr();
        ins.opcode    = op;
        ins.rs_value  = rs;
        ins.rt_value  = rt;
        ins.immediate = imm;
        return ins;
    endfunction

    task automatic send_instr(exec_instr_t ins, int idle_pct);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(3, 1) : 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start        <= 1'b1;
        i_opcode       <= ins.opcode;
        i_rs_value     <= ins.rs_value;
        i_rt_value     <= ins.rt_value;
        i_immediate    <= ins.immediate;
        i_rt_index     <= ins.rt_index;
        i_rd_index     <= ins.rd_index;
        i_shift_amount <= ins.shift_amount;
        i_jump_target  <= ins.jump_target;
        i_pc_value     <= ins.pc_value;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // Stops issuing and waits until every outstanding transaction has produced its result.
    task automatic wait_for_results(int settle);
        int spins;
        spins = 0;
        i_start <= 1'b0;
        do begin
            @(posedge i_clk);
            spins++;
        end while (tracker.outstanding() != 0 && spins < 1000);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_settings(logic mode64, logic kernel, logic exc_on);
        wait_for_results(4);
        write_register(CFG_MODE_64BIT, mode64);
        write_register(CFG_KERNEL_MODE, kernel);
        write_register(CFG_EXC_ENABLE, exc_on);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        exec_instr_t d;
        logic [2:0]  settings [6];
        int          idle_pcts [4];
        settings  = '{3'b011, 3'b001, 3'b101, 3'b110, 3'b000, 3'b111};
        idle_pcts = '{0, 53, 0, 38};

        i_rst_n        <= 1'b0;
        i_start        <= 1'b0;
        i_opcode       <= '0;
        i_rs_value     <= '0;
        i_rt_value     <= '0;
        i_immediate    <= '0;
        i_rt_index     <= '0;
        i_rd_index     <= '0;
        i_shift_amount <= '0;
        i_jump_target  <= '0;
        i_pc_value     <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed instructions under the reset register values.
        send_instr(instr_with(OP_ADDI, 64'h7fff_ffff, '0, 16'h0001), 0);
        send_instr(instr_with(OP_ADDI, 64'h8000_0000, '0, 16'hffff), 0);
        send_instr(instr_with(OP_ADDIU, 64'h7fff_ffff, '0, 16'h0001), 0);
        send_instr(instr_with(OP_ADD, 64'h7fff_ffff, 64'h7fff_ffff, '0), 0);
        send_instr(instr_with(OP_ADDU, '1, '1, '0), 0);
        d = instr_with(OP_J, '0, '0, '0);
        d.pc_value    = '0;
        d.jump_target = '1;
        send_instr(d, 0);
        d = instr_with(OP_JAL, '0, '0, '0);
        d.pc_value    = '1;
        d.jump_target = '0;
        send_instr(d, 0);
        send_instr(instr_with(OP_LUI, '0, '0, 16'h8000), 0);
        send_instr(instr_with(OP_ORI, '0, '0, 16'hffff), 0);
        send_instr(instr_with(OP_ANDI, '1, '0, 16'hffff), 0);
        send_instr(instr_with(OP_SD, 64'd4, '1, 16'h0000), 0);
        send_instr(instr_with(OP_SW, 64'hffff_fffc, '1, 16'h0000), 0);
        send_instr(instr_with(OP_LBU, 64'hffff_ffff, '0, 16'h7fff), 0);
        send_instr(instr_with(OP_LHU, 64'd1, '0, 16'h0000), 0);
        send_instr(instr_with(OP_LW, 64'd2, '0, 16'h0000), 0);
        send_instr(instr_with(OP_LD, 64'h10, '0, 16'hfff8), 0);
        send_instr(instr_with(OP_BEQ, '1, '1, 16'h8000), 0);
        send_instr(instr_with(OP_BNE, 64'd5, 64'd5, 16'h7fff), 0);
        send_instr(instr_with(OP_BNE, 64'd5, 64'd6, 16'hffff), 0);
        send_instr(instr_with(OP_JR, 64'd2, '0, '0), 0);
        send_instr(instr_with(OP_JALR, '1 << 2, '0, '0), 0);
        d = instr_with(OP_SLL, '0, 64'd1, '0);
        d.shift_amount = 5'd31;
        send_instr(d, 0);
        send_instr(instr_with(OP_SLT, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, '0), 0);
        send_instr(instr_with(OP_NOP, '1, '1, '1), 0);
        send_instr(instr_with(FIRST_UNIMPL_OP, '0, '0, '0), 0);
        send_instr(instr_with(LAST_UNIMPL_OP, '1, '1, '1), 0);

        // 32-bit user mode: reserved instruction must win over a misaligned address.
        apply_settings(1'b0, 1'b0, 1'b1);
        send_instr(instr_with(OP_LD, 64'd3, '0, 16'h0000), 0);
        send_instr(instr_with(OP_SD, 64'd8, '1, 16'h0000), 0);

        foreach (settings[p]) begin
            apply_settings(settings[p][2], settings[p][1], settings[p][0]);
            foreach (idle_pcts[s]) begin
                for (int n = 0; n < 67; n++) begin
                    if (s == 1 && n == 30) begin
                        wait_for_results(0);
                    end
                    send_instr(random_instr(), idle_pcts[s]);
                end
            end
        end

        wait_for_results(4);
        tracker.report_leftovers();
        $display("Issued %0d instructions and checked %0d results with %0d mismatches.",
                 tracker.instrs_noted, tracker.results_checked, tracker.errors);
        $display("Covered every opcode under six register settings and four idle patterns.");
        if (tracker.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
